// ===== rtl/gmce_pkg.sv =====
// shared types, constants and codes for the graph m-coloring enumerator
package gmce_pkg;

    localparam int MAX_VERTICES_DEF = 16;

    localparam int OP_W       = 2;
    localparam int ROW_IDX_W  = 4;
    localparam int ROW_W      = 16;
    localparam int COLOR_W    = 4;
    localparam int VCNT_W     = 5;
    localparam int COLORING_W = 64;
    localparam int SOL_W      = 32;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
    localparam logic [OP_W-1:0] OP_NEXT    = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_COLORS   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VERTEX_COUNT = 1'd1;

    localparam logic [COLOR_W-1:0] NUM_COLORS_RST   = 4'd3;
    localparam logic [VCNT_W-1:0]  VERTEX_COUNT_RST = 5'd4;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [ROW_IDX_W-1:0] row_index;
        logic [ROW_W-1:0]     row_bits;
    } t_cmd;

    typedef struct packed {
        logic                  found;
        logic                  exhausted;
        logic [COLORING_W-1:0] coloring;
        logic [SOL_W-1:0]      solution_number;
    } t_result;

    typedef enum logic [1:0] {
        RES_PLAIN,
        RES_EXH,
        RES_FOUND
    } t_res_kind;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_READY,
        MODE_RESUME,
        MODE_DONE
    } t_mode;

    typedef struct packed {
        logic      load;
        logic      restart;
        logic      init;
        logic      resume;
        logic      step;
        logic      emit;
        t_res_kind kind;
    } t_dp_ctl;

    typedef struct packed {
        logic placed;
        logic last;
        logic root;
    } t_dp_stat;

endpackage

// ===== rtl/gmce_controller.sv =====
// search controller: transaction decode, search mode and backtracking sequencing
module gmce_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [gmce_pkg::OP_W-1:0] i_op,
    input  gmce_pkg::t_dp_stat i_stat,
    output gmce_pkg::t_dp_ctl  o_ctl,
    output logic               busy
);
    import gmce_pkg::*;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MODE_IDLE;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        o_ctl   = '0;
        o_ctl.kind = RES_PLAIN;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_op)
                        OP_LOAD: begin
                            o_ctl.load = 1'b1;
                            o_ctl.emit = 1'b1;
                        end
                        OP_RESTART: begin
                            o_ctl.restart = 1'b1;
                            o_ctl.emit    = 1'b1;
                            n_mode        = MODE_READY;
                        end
                        OP_NEXT: begin
                            case (r_mode)
                                MODE_DONE: begin
                                    o_ctl.emit = 1'b1;
                                    o_ctl.kind = RES_EXH;
                                end
                                MODE_IDLE: begin
                                    o_ctl.emit = 1'b1;
                                end
                                default: begin
                                    o_ctl.init   = 1'b1;
                                    o_ctl.resume = (r_mode == MODE_RESUME);
                                    n_state      = ST_SEARCH;
                                end
                            endcase
                        end
                        default: begin
                            o_ctl.emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                o_ctl.step = 1'b1;
                if (i_stat.placed && i_stat.last) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.kind = RES_FOUND;
                    n_mode     = MODE_RESUME;
                    n_state    = ST_IDLE;
                end else if (!i_stat.placed && i_stat.root) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.kind = RES_EXH;
                    n_mode     = MODE_DONE;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state == ST_SEARCH);

endmodule

// ===== rtl/gmce_datapath.sv =====
// search datapath: adjacency rows, vertex colors, vertex pointer, counter and result register
module gmce_datapath #(
    parameter int MAX_VERTICES = gmce_pkg::MAX_VERTICES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gmce_pkg::t_cmd                    i_cmd,
    input  logic                              i_cfg_we,
    input  logic [gmce_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [gmce_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  gmce_pkg::t_dp_ctl                 i_ctl,
    output gmce_pkg::t_dp_stat                o_stat,
    output logic                              o_result_strobe,
    output gmce_pkg::t_result                 o_result
);
    import gmce_pkg::*;

    localparam int VW      = $clog2(MAX_VERTICES);
    localparam int NW      = $clog2(MAX_VERTICES + 1);
    localparam int NCOLORS = 2 ** COLOR_W;

    logic [COLOR_W-1:0]      r_num_colors;
    logic [VCNT_W-1:0]       r_vertex_count;
    logic [MAX_VERTICES-1:0] r_adj [MAX_VERTICES];
    logic [COLOR_W-1:0]      r_colors [MAX_VERTICES];
    logic [COLOR_W-1:0]      n_colors [MAX_VERTICES];
    logic [NW-1:0]           r_vtx, n_vtx;
    logic [SOL_W-1:0]        r_count, n_count;
    logic                    r_strobe;
    t_result                 r_result, n_result;

    logic [NW-1:0]           w_n;
    logic [VW-1:0]           w_v;
    logic [MAX_VERTICES-1:0] w_row;
    logic [COLOR_W-1:0]      w_cur;
    logic [NCOLORS-1:0]      w_forbid;
    logic                    w_placed;
    logic [COLOR_W-1:0]      w_color;
    logic                    w_last;
    logic                    w_root;
    logic [COLORING_W-1:0]   w_packed;

    // vertex count clamped to 1..MAX_VERTICES
    always_comb begin
        if (r_vertex_count == '0) begin
            w_n = NW'(1);
        end else if (r_vertex_count > VCNT_W'(MAX_VERTICES)) begin
            w_n = NW'(MAX_VERTICES);
        end else begin
            w_n = r_vertex_count[NW-1:0];
        end
    end

    assign w_v   = r_vtx[VW-1:0];
    assign w_row = r_adj[w_v];
    assign w_cur = r_colors[w_v];

    // colors taken by already colored neighbors
    always_comb begin
        w_forbid = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if ((NW'(i) < r_vtx) && w_row[i]) begin
                w_forbid[r_colors[i]] = 1'b1;
            end
        end
    end

    // lowest fitting color above the current one
    always_comb begin
        w_placed = 1'b0;
        w_color  = '0;
        for (int c = NCOLORS - 1; c >= 1; c--) begin
            if ((COLOR_W'(c) > w_cur) && (COLOR_W'(c) <= r_num_colors) && !w_forbid[c]) begin
                w_placed = 1'b1;
                w_color  = COLOR_W'(c);
            end
        end
    end

    assign w_last = ((r_vtx + NW'(1)) >= w_n);
    assign w_root = (r_vtx == '0);

    assign o_stat.placed = w_placed;
    assign o_stat.last   = w_last;
    assign o_stat.root   = w_root;

    always_comb begin
        n_colors = r_colors;
        n_vtx    = r_vtx;
        n_count  = r_count;
        if (i_ctl.restart) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                n_colors[i] = '0;
            end
            n_vtx   = '0;
            n_count = '0;
        end
        if (i_ctl.init) begin
            if (i_ctl.resume) begin
                for (int i = 0; i < MAX_VERTICES; i++) begin
                    if (NW'(i) >= w_n) begin
                        n_colors[i] = '0;
                    end
                end
                n_vtx = w_n - NW'(1);
            end else begin
                n_vtx = '0;
            end
        end
        if (i_ctl.step) begin
            if (w_placed) begin
                n_colors[w_v] = w_color;
                if (!w_last) begin
                    n_vtx = r_vtx + NW'(1);
                end
            end else begin
                n_colors[w_v] = '0;
                if (!w_root) begin
                    n_vtx = r_vtx - NW'(1);
                end
            end
        end
        if (i_ctl.emit && (i_ctl.kind == RES_FOUND) && (r_count != '1)) begin
            n_count = r_count + SOL_W'(1);
        end
    end

    always_comb begin
        w_packed = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            w_packed[COLOR_W*i +: COLOR_W] = n_colors[i];
        end
    end

    always_comb begin
        n_result.found           = (i_ctl.kind == RES_FOUND);
        n_result.exhausted       = (i_ctl.kind == RES_EXH);
        n_result.coloring        = (i_ctl.kind == RES_FOUND) ? w_packed : '0;
        n_result.solution_number = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_colors   <= NUM_COLORS_RST;
            r_vertex_count <= VERTEX_COUNT_RST;
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_adj[i]    <= '0;
                r_colors[i] <= '0;
            end
            r_vtx    <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_result <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_NUM_COLORS:   r_num_colors   <= i_cfg_wdata[COLOR_W-1:0];
                    CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_wdata[VCNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_ctl.load &&
                ({1'b0, i_cmd.row_index} < (ROW_IDX_W + 1)'(MAX_VERTICES))) begin
                r_adj[i_cmd.row_index[VW-1:0]] <= i_cmd.row_bits[MAX_VERTICES-1:0];
            end
            r_colors <= n_colors;
            r_vtx    <= n_vtx;
            r_count  <= n_count;
            r_strobe <= i_ctl.emit;
            if (i_ctl.emit) begin
                r_result <= n_result;
            end
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

endmodule

// ===== rtl/graph_m_coloring_enumerator.sv =====
// top level of the graph m-coloring enumerator
// A transaction is taken when start is high and busy is low. Load, restart and
// unused ops, and a next request when the search is idle or exhausted, are
// handled without a search; their result strobes in the following cycle. A next
// request that resumes the search first sets up the start vertex and then runs the
// depth-first search (each step places the lowest fitting color above the current
// one on the current vertex or backs up one vertex), so its length depends on the
// graph. busy stays high for that time and the result strobes once, in the cycle
// in which busy falls. The receiver cannot stall: each result is on o_result for
// exactly one cycle, marked by o_result_strobe, and must be taken then.
module graph_m_coloring_enumerator #(
    parameter int MAX_VERTICES = gmce_pkg::MAX_VERTICES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  gmce_pkg::t_cmd                  i_cmd,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic [gmce_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [gmce_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                            o_result_strobe,
    output gmce_pkg::t_result               o_result
);
    import gmce_pkg::*;

    t_dp_ctl  w_ctl;
    t_dp_stat w_stat;

    gmce_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_cmd.op),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl),
        .busy    (busy)
    );

    gmce_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (i_cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_ctl           (w_ctl),
        .o_stat          (w_stat),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

endmodule

// ===== test/graph_m_coloring_enumerator_test.sv =====
// self-checking testbench for the graph m-coloring enumerator: directed and random command streams
module graph_m_coloring_enumerator_test;
    import gmce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV          = MAX_VERTICES_DEF;
    localparam int CLK_PERIOD  = 4;
    localparam int RESET_LEN   = 5;
    localparam int SETTLE      = 4;
    localparam int STALL_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam int SEG_ITEMS   = 40;
    localparam int SEGMENTS    = 10;
    localparam longint TREE_CAP = 2048;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    t_cmd                  i_cmd;
    logic                  busy;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  o_result_strobe;
    t_result               o_result;

    // mirror of the search state
    logic [ROW_W-1:0]   graph_rows [NV];
    logic [COLOR_W-1:0] vertex_color [NV];
    t_mode              search_mode;
    logic [SOL_W-1:0]   model_count;
    logic [COLOR_W-1:0] max_color;
    logic [VCNT_W-1:0]  vertex_limit;

    t_result outcome_fifo [$];

    int sender_idle;
    int mismatches;
    int cmd_count;
    int found_count;
    int exhausted_count;
    int reg_writes;
    int idle_cycles;
    logic [SOL_W-1:0] top_solution;

    graph_m_coloring_enumerator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_cmd           (i_cmd),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic bit color_fits(int v, int c);
        int i;
        for (i = 0; i < v; i++) begin
            if (graph_rows[v][i] && vertex_color[i] == c) return 1'b0;
        end
        return 1'b1;
    endfunction

    // depth-first walk from vertex v; true when all n vertices hold a color
    function automatic bit extend_coloring(int v, int n);
        int c;
        bit placed;
        while (1'b1) begin
            c = int'(vertex_color[v]) + 1;
            placed = 1'b0;
            while (!placed && c <= int'(max_color)) begin
                if (color_fits(v, c)) placed = 1'b1;
                else c++;
            end
            if (placed) begin
                vertex_color[v] = COLOR_W'(c);
                v++;
                if (v >= n) return 1'b1;
            end else begin
                vertex_color[v] = '0;
                if (v == 0) return 1'b0;
                v--;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_result search_outcome(t_cmd c);
        t_result r;
        int n;
        int first;
        int i;
        r = '0;
        case (c.op)
            OP_LOAD: begin
                graph_rows[c.row_index] = c.row_bits;
            end
            OP_RESTART: begin
                for (i = 0; i < NV; i++) vertex_color[i] = '0;
                model_count = '0;
                search_mode = MODE_READY;
            end
            OP_NEXT: begin
                if (search_mode == MODE_DONE) begin
                    r.exhausted = 1'b1;
                end else if (search_mode != MODE_IDLE) begin
                    n = (vertex_limit == 0) ? 1 : (vertex_limit > NV) ? NV : int'(vertex_limit);
                    first = 0;
                    if (search_mode == MODE_RESUME) begin
                        for (i = n; i < NV; i++) vertex_color[i] = '0;
                        first = n - 1;
                    end
                    if (extend_coloring(first, n)) begin
                        if (model_count != '1) model_count++;
                        search_mode = MODE_RESUME;
                        r.found = 1'b1;
                        for (i = 0; i < NV; i++)
                            r.coloring[COLOR_W*i +: COLOR_W] = vertex_color[i];
                    end else begin
                        search_mode = MODE_DONE;
                        r.exhausted = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.solution_number = model_count;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_result_strobe) begin
            if (outcome_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: found=%0b exh=%0b col=%h num=%0d",
                             o_result.found, o_result.exhausted, o_result.coloring,
                             o_result.solution_number);
            end else begin
                want = outcome_fifo.pop_front();
                if (o_result.found !== want.found || o_result.exhausted !== want.exhausted ||
                    o_result.coloring !== want.coloring ||
                    o_result.solution_number !== want.solution_number) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: exp found=%0b exh=%0b col=%h num=%0d, ",
                                  "got found=%0b exh=%0b col=%h num=%0d"},
                                 want.found, want.exhausted, want.coloring, want.solution_number,
                                 o_result.found, o_result.exhausted, o_result.coloring,
                                 o_result.solution_number);
                end
                if (want.found) found_count++;
                if (want.exhausted) exhausted_count++;
                if (want.solution_number > top_solution) top_solution = want.solution_number;
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_strobe) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_cmd(logic [OP_W-1:0] op, logic [ROW_IDX_W-1:0] idx,
                            logic [ROW_W-1:0] bits);
        t_cmd c;
        c.op = op;
        c.row_index = idx;
        c.row_bits = bits;
        while ($urandom_range(99) < sender_idle) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        outcome_fifo.push_back(search_outcome(c));
        cmd_count++;
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        while (outcome_fifo.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        if (addr == CFG_NUM_COLORS) max_color = value[COLOR_W-1:0];
        else vertex_limit = value[VCNT_W-1:0];
        reg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_config(int colors, int vcount, bit spare_bit);
        wait_quiet();
        write_register(CFG_NUM_COLORS, {spare_bit, COLOR_W'(colors)});
        write_register(CFG_VERTEX_COUNT, VCNT_W'(vcount));
    endtask

    task automatic test_idle_and_first_solutions();
        send_cmd(OP_NEXT, 4'd0, 16'h0000);
        send_cmd(OP_UNUSED, 4'd15, 16'hFFFF);
        send_cmd(OP_RESTART, 4'd0, 16'h0000);
        send_cmd(OP_NEXT, 4'd0, 16'h0000);
        send_cmd(OP_LOAD, 4'd1, 16'hFFFF);
        send_cmd(OP_LOAD, 4'd15, 16'hFFFF);
        send_cmd(OP_NEXT, 4'd0, 16'h0000);
        send_cmd(OP_UNUSED, 4'd0, 16'h0000);
        send_cmd(OP_LOAD, 4'd0, 16'h0001);
    endtask

    task automatic test_zero_colors();
        apply_config(0, 4, 1'b0);
        send_cmd(OP_RESTART, 4'd0, 16'h0000);
        send_cmd(OP_NEXT, 4'd0, 16'h0000);
        send_cmd(OP_NEXT, 4'd0, 16'h0000);
        send_cmd(OP_UNUSED, 4'd7, 16'h5A5A);
    endtask

    task automatic test_wide_graph();
        apply_config(15, 31, 1'b1);
        send_cmd(OP_RESTART, 4'd0, 16'h0000);
        send_cmd(OP_NEXT, 4'd0, 16'h0000);
        send_cmd(OP_NEXT, 4'd0, 16'h0000);
        // shrink the graph while the search holds a solution
        wait_quiet();
        write_register(CFG_VERTEX_COUNT, 5'd3);
        send_cmd(OP_NEXT, 4'd0, 16'h0000);
    endtask

    task automatic test_single_vertex();
        apply_config(1, 0, 1'b0);
        send_cmd(OP_RESTART, 4'd0, 16'h0000);
        send_cmd(OP_NEXT, 4'd0, 16'h0000);
        send_cmd(OP_NEXT, 4'd0, 16'h0000);
        send_cmd(OP_NEXT, 4'd0, 16'h0000);
    endtask

    task automatic test_dead_end();
        apply_config(2, 4, 1'b0);
        send_cmd(OP_LOAD, 4'd3, 16'hFFFF);
        send_cmd(OP_RESTART, 4'd0, 16'h0000);
        send_cmd(OP_NEXT, 4'd0, 16'h0000);
        send_cmd(OP_NEXT, 4'd0, 16'h0000);
    endtask

    task automatic test_random_search(int idle_pct);
        int seg;
        int k;
        int colors;
        int vcount;
        int used;
        int r;
        logic [OP_W-1:0] op;
        logic [ROW_IDX_W-1:0] idx;
        logic [ROW_W-1:0] bits;
        sender_idle = idle_pct;
        for (seg = 0; seg < SEGMENTS; seg++) begin
            case ($urandom_range(9))
                0: colors = 0;
                1: colors = 1;
                2: colors = 15;
                default: colors = $urandom_range(15, 2);
            endcase
            case ($urandom_range(9))
                0: vcount = 0;
                1: vcount = 31;
                2: vcount = 16;
                3: vcount = $urandom_range(30, 17);
                default: vcount = $urandom_range(16, 1);
            endcase
            used = (vcount == 0) ? 1 : (vcount > NV) ? NV : vcount;
            // keep the backtracking tree small when dead ends are possible
            if (colors >= 2 && colors < used && longint'(colors) ** used > TREE_CAP) begin
                while (colors < used && longint'(colors) ** used > TREE_CAP) used--;
                vcount = used;
            end
            apply_config(colors, vcount, 1'($urandom_range(1)));
            for (k = 0; k < SEG_ITEMS; k++) begin
                r = $urandom_range(99);
                if ((k == 0 && r < 75) || (k > 0 && r < 7)) op = OP_RESTART;
                else if (r < 32) op = OP_LOAD;
                else if (r < 35) op = OP_UNUSED;
                else op = OP_NEXT;
                if (op == OP_LOAD && $urandom_range(99) < 70)
                    idx = ROW_IDX_W'($urandom_range(used - 1));
                else
                    idx = ROW_IDX_W'($urandom_range(15));
                case ($urandom_range(3))
                    0: bits = ROW_W'($urandom);
                    1: bits = ROW_W'($urandom & $urandom & $urandom);
                    2: bits = '0;
                    default: bits = '1;
                endcase
                send_cmd(op, idx, bits);
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cmd <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= '0;
        i_cfg_wdata <= '0;
        for (int i = 0; i < NV; i++) begin
            graph_rows[i] = '0;
            vertex_color[i] = '0;
        end
        search_mode = MODE_IDLE;
        model_count = '0;
        max_color = NUM_COLORS_RST;
        vertex_limit = VERTEX_COUNT_RST;
        sender_idle = 18;
        mismatches = 0;
        cmd_count = 0;
        found_count = 0;
        exhausted_count = 0;
        reg_writes = 0;
        idle_cycles = 0;
        top_solution = '0;
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_and_first_solutions();
        test_zero_colors();
        test_wide_graph();
        test_single_vertex();
        test_dead_end();
        test_random_search(18);
        test_random_search(86);
        test_random_search(0);

        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (outcome_fifo.size() != 0) begin
            $display("%0d results never arrived", outcome_fifo.size());
            mismatches += outcome_fifo.size();
        end
        $display("checked %0d transactions: %0d colorings, %0d exhausted reports, top count %0d",
                 cmd_count, found_count, exhausted_count, top_solution);
        $display("%0d register writes, sender idle rates 18, 86 and 0 percent, %0d mismatches",
                 reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
